// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the list RTL; empty when synthesising.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Clocked property, disabled while reset is held
`define ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("list assertion failed");

// Same, with a caller-supplied message
`define ASSERT_CLK_MSG(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

`else

`define ASSERT_CLK(label, prop)
`define ASSERT_CLK_MSG(label, prop, msg)

`endif

`endif

// ----- rtl/ilps_pkg.sv -----
// Types and constants of the integer list with push and search.
package ilps_pkg;

  localparam int unsigned ValueW  = 32;
  localparam int unsigned ModeW   = 2;
  localparam int unsigned PosW    = 4;
  localparam int unsigned CountW  = 5;
  localparam int unsigned InDataW = 32;
  localparam int unsigned OutDataW = 16;

  // Operation codes carried in in_tuser
  typedef enum logic [ModeW-1:0] {
    MODE_TAIL  = 2'd0,
    MODE_HEAD  = 2'd1,
    MODE_FIND  = 2'd2,
    MODE_COUNT = 2'd3
  } ilps_mode_t;

  // Controller states, one-hot
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_FIND = 2'b10
  } ilps_state_t;

  // Per-cycle command broadcast along the cell row
  typedef struct packed {
    logic              push_head;
    logic              push_tail;
    logic              compare;
    logic [ValueW-1:0] value;
  } ilps_cmd_t;

endpackage

// ----- rtl/ilps_cell.sv -----
// One list cell: holds an entry, shifts from its left neighbour, flags a match.
module ilps_cell #(
  parameter int unsigned IDX    = 0,
  parameter int unsigned CNT_W  = 5
) (
  input  logic                        clk,
  input  ilps_pkg::ilps_cmd_t         cmd,
  input  logic [CNT_W-1:0]            held,
  input  logic [ilps_pkg::ValueW-1:0] left_data,
  output logic [ilps_pkg::ValueW-1:0] data,
  output logic                        match
);
  import ilps_pkg::*;

  logic [ValueW-1:0] data_r;
  logic [ValueW-1:0] data_nxt;
  logic              match_r;
  logic              in_use;

  assign in_use = ({1'b0, held} > (CNT_W+1)'(IDX));

  // Entry update: head push shifts the row, tail push fills slot held
  always_comb begin
    data_nxt = data_r;
    if (cmd.push_head) begin
      data_nxt = (IDX == 0) ? cmd.value : left_data;
    end else if (cmd.push_tail && ({1'b0, held} == (CNT_W+1)'(IDX))) begin
      data_nxt = cmd.value;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    if (cmd.compare) begin
      match_r <= in_use && (data_r == cmd.value);
    end
  end

  assign data  = data_r;
  assign match = match_r;

endmodule

// ----- rtl/ilps_first_match.sv -----
// Priority encoder: index of the lowest set match flag along the row.
module ilps_first_match #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned IDX_W = 4
) (
  input  logic [DEPTH-1:0] match,
  output logic             any,
  output logic [IDX_W-1:0] index
);

  // Scan from the tail so the head-most hit wins
  always_comb begin
    index = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (match[i]) begin
        index = IDX_W'(i);
      end
    end
  end

  assign any = |match;

endmodule

// ----- rtl/integer_list_push_search_top.sv -----
// Top level of the integer list: controller, cell row and result register.
//
//  Channel | Ports        | Payload (lowest bit first)
//  --------+--------------+-----------------------------------------------
//  input   | in_t*        | tuser: mode[1:0]; tdata: value[31:0]
//  result  | out_t*       | tdata: found, position[3:0], entry_count[4:0],
//          |              |        overflow, zero pad[15:11]
//
//  Push-tail, push-head and count have their result registered at the input
//  transfer. For a search the cells first register their compares, then the
//  first-match encoder loads the result register.
//  Input is taken while no search is under way and the result register is
//  empty or being emptied in the same cycle. Reset clears the entry count and
//  the handshake state; entry contents need no clearing.
`include "assert_macros.svh"

module integer_list_push_search_top #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [ilps_pkg::ModeW-1:0]    in_tuser,   // mode
  input  logic [ilps_pkg::InDataW-1:0]  in_tdata,   // value
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [ilps_pkg::OutDataW-1:0] out_tdata   // found, position, entry_count, overflow
);
  import ilps_pkg::*;

  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  ilps_state_t       state_r, state_nxt;
  logic [CntW-1:0]   held_r, held_nxt;
  logic              out_valid_r;
  logic [OutDataW-1:0] out_data_r;

  logic              in_fire;
  logic              full;
  ilps_mode_t        mode;
  logic              is_push;
  ilps_cmd_t         cmd;

  logic [ValueW-1:0] cell_data [DEPTH];
  logic [DEPTH-1:0]  match;
  logic              hit;
  logic [IdxW-1:0]   hit_idx;

  logic              res_found;
  logic [PosW-1:0]   res_pos;
  logic              res_ovf;
  logic              load_out;

  assign mode    = ilps_mode_t'(in_tuser);
  assign in_fire = in_tvalid && in_tready;
  assign full    = (held_r == CntW'(DEPTH));
  assign is_push = (mode == MODE_TAIL) || (mode == MODE_HEAD);

  assign in_tready = (state_r == ST_IDLE) && (!out_valid_r || out_tready);

  // Command broadcast to the cell row
  always_comb begin
    cmd.value     = in_tdata[ValueW-1:0];
    cmd.push_head = in_fire && (mode == MODE_HEAD) && !full;
    cmd.push_tail = in_fire && (mode == MODE_TAIL) && !full;
    cmd.compare   = in_fire && (mode == MODE_FIND);
  end

  // Cell row; each cell takes its left neighbour's entry on a head push
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [ValueW-1:0] left;
    if (g == 0) begin : g_head
      assign left = in_tdata[ValueW-1:0];
    end else begin : g_body
      assign left = cell_data[g-1];
    end
    ilps_cell #(
      .IDX   (g),
      .CNT_W (CntW)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .held      (held_r),
      .left_data (left),
      .data      (cell_data[g]),
      .match     (match[g])
    );
  end

  ilps_first_match #(
    .DEPTH (DEPTH),
    .IDX_W (IdxW)
  ) u_first_match (
    .match (match),
    .any   (hit),
    .index (hit_idx)
  );

  // Controller and entry count
  always_comb begin
    state_nxt = state_r;
    held_nxt  = held_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (mode == MODE_FIND) begin
            state_nxt = ST_FIND;
          end else if (is_push && !full) begin
            held_nxt = held_r + CntW'(1);
          end
        end
      end
      ST_FIND: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Result fields
  always_comb begin
    res_found = 1'b0;
    res_pos   = '0;
    res_ovf   = 1'b0;
    load_out  = 1'b0;
    if (state_r == ST_FIND) begin
      load_out  = 1'b1;
      res_found = hit;
      res_pos   = hit ? PosW'(hit_idx) : '0;
    end else if (in_fire && (mode != MODE_FIND)) begin
      load_out  = 1'b1;
      res_ovf   = is_push && full;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      held_r  <= held_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result register; entry count is the value after this item
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r <= {5'd0, res_ovf, CountW'(held_nxt), res_pos, res_found};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Checks
  `ASSERT_CLK_MSG(a_held_bound, held_r <= CntW'(DEPTH), "entry count beyond depth")
  `ASSERT_CLK_MSG(a_find_slot_free, (state_r == ST_FIND) |-> !out_valid_r,
                  "result register busy when search completes")
  `ASSERT_CLK(a_overflow_flag,
              (in_fire && is_push && full) |=> (out_valid_r && out_data_r[10]))
  `ASSERT_CLK(a_held_steady, !in_fire |=> (held_r == $past(held_r)))
  `ASSERT_CLK(a_find_no_count_change,
              (in_fire && (mode == MODE_FIND)) |=> (held_r == $past(held_r)))

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the integer list with push and search.
`timescale 1ns / 1ps

module testbench;
  import ilps_pkg::*;

  localparam int Depth       = 16;
  localparam int NumRandom   = 1375;
  localparam int LongHold    = 400;
  localparam int CycleLimit  = 1000000;

  // One expected reply, fields as they sit in out_tdata
  typedef struct packed {
    logic                overflow;
    logic [CountW-1:0]   entry_count;
    logic [PosW-1:0]     position;
    logic                found;
  } list_reply_t;

  // Scoreboard: keeps its own copy of the list and the replies still owed
  class list_scoreboard;
    logic [ValueW-1:0] cells [Depth];
    int unsigned       held;
    list_reply_t       owed_replies [$];
    int                errors;
    int                hits, misses, dropped, deepest;

    function new();
      held    = 0;
      errors  = 0;
      hits    = 0;
      misses  = 0;
      dropped = 0;
      deepest = 0;
    endfunction

    function int pending();
      return owed_replies.size();
    endfunction

    // Apply one accepted item to the list copy and queue its reply
    function void note_item(ilps_mode_t mode, logic [ValueW-1:0] value);
      list_reply_t r;
      r = '0;
      case (mode)
        MODE_TAIL, MODE_HEAD: begin
          if (held >= Depth) begin
            r.overflow = 1'b1;
            dropped++;
          end else if (mode == MODE_TAIL) begin
            cells[held] = value;
            held++;
          end else begin
            for (int i = held; i > 0; i--) cells[i] = cells[i-1];
            cells[0] = value;
            held++;
          end
        end
        MODE_FIND: begin
          for (int i = 0; i < held; i++) begin
            if (!r.found && cells[i] == value) begin
              r.found    = 1'b1;
              r.position = PosW'(i);
            end
          end
          if (r.found) begin
            hits++;
            if (r.position > deepest) deepest = r.position;
          end else begin
            misses++;
          end
        end
        default: ;
      endcase
      r.entry_count = CountW'(held);
      owed_replies.push_back(r);
    endfunction

    // Compare one result transfer with the oldest owed reply
    function void check_result(logic [OutDataW-1:0] data);
      list_reply_t want, got;
      got = data[$bits(list_reply_t)-1:0];
      if (owed_replies.size() == 0) begin
        $error("result 0x%h arrived with no item outstanding", data);
        errors++;
        return;
      end
      want = owed_replies.pop_front();
      if (got.found !== want.found) begin
        $error("found: expected %0d, got %0d", want.found, got.found);
        errors++;
      end
      if (got.position !== want.position) begin
        $error("position: expected %0d, got %0d", want.position, got.position);
        errors++;
      end
      if (got.entry_count !== want.entry_count) begin
        $error("entry_count: expected %0d, got %0d", want.entry_count, got.entry_count);
        errors++;
      end
      if (got.overflow !== want.overflow) begin
        $error("overflow: expected %0d, got %0d", want.overflow, got.overflow);
        errors++;
      end
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [ModeW-1:0]    in_tuser;   // mode
  logic [InDataW-1:0]  in_tdata;   // value
  logic                out_tvalid;
  logic                out_tready;
  logic [OutDataW-1:0] out_tdata;  // found, position, entry_count, overflow

  list_scoreboard sb;
  bit             calm;          // no idling on either side while set
  bit             long_hold_req;
  int             items_sent;
  int             cycle_count;

  integer_list_push_search_top #(.DEPTH(Depth)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Idle length: mostly short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 50);
  endfunction

  // Offer one item and wait for its transfer
  task automatic send_item(ilps_mode_t mode, logic [ValueW-1:0] value);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 99) < 30) gap = idle_len();
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= value;
    do @(posedge clk); while (!in_tready);
    sb.note_item(mode, value);
    items_sent++;
  endtask

  // Empty-list cases, both push ends at the value extremes, duplicates,
  // filling up, pushes into a full list and a hit on the last entry
  task automatic run_directed();
    send_item(MODE_COUNT, 32'h0);
    send_item(MODE_FIND, 32'h0);
    send_item(MODE_TAIL, 32'h8000_0000);
    send_item(MODE_HEAD, 32'h7fff_ffff);
    send_item(MODE_FIND, 32'h8000_0000);
    send_item(MODE_TAIL, 32'hffff_ffff);
    send_item(MODE_HEAD, 32'h0);
    send_item(MODE_FIND, 32'hffff_ffff);
    send_item(MODE_FIND, 32'h1);
    send_item(MODE_TAIL, 32'h0);
    send_item(MODE_FIND, 32'h0);
    for (int k = 0; k < Depth - 5; k++)
      send_item(ilps_mode_t'((k % 2) ? MODE_HEAD : MODE_TAIL),
                32'hA5A5_0000 + 32'h0101 * k);
    send_item(MODE_TAIL, 32'd42);
    send_item(MODE_HEAD, 32'd43);
    send_item(MODE_FIND, sb.cells[Depth-1]);
    send_item(MODE_COUNT, 32'h0);
  endtask

  // Random items, weighted towards searches that hit the list
  task automatic run_random();
    ilps_mode_t        mode;
    logic [ValueW-1:0] value;
    int                pick, small_val;
    for (int n = 0; n < NumRandom; n++) begin
      if (n == 300) long_hold_req = 1'b1;
      if (n == 700) begin
        // let the block drain completely before carrying on
        @(negedge clk);
        in_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge clk);
      end
      calm = (n >= 1000 && n < 1200);

      pick = $urandom_range(0, 99);
      if (pick < 55)      mode = MODE_FIND;
      else if (pick < 70) mode = MODE_TAIL;
      else if (pick < 85) mode = MODE_HEAD;
      else                mode = MODE_COUNT;

      pick = $urandom_range(0, 9);
      if (mode == MODE_FIND && pick < 6 && sb.held > 0) begin
        value = sb.cells[$urandom_range(0, sb.held - 1)];
      end else if (pick < 8) begin
        small_val = $urandom_range(0, 4);
        value = small_val - 2;
      end else begin
        value = $urandom;
      end
      send_item(mode, value);
    end
  endtask

  // Result side: random stalls plus one long hold on request
  initial begin
    int hold_left;
    hold_left  = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_tready <= 1'b0;
        hold_left = LongHold - 1;
      end else if (!calm && rst_n && $urandom_range(0, 99) < 12) begin
        out_tready <= 1'b0;
        hold_left = idle_len() - 1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Result transfers
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d replies outstanding", cycle_count, sb.pending());
    $display("testbench: errors");
    $finish;
  end

  // Main sequence
  initial begin
    sb            = new();
    calm          = 1'b0;
    long_hold_req = 1'b0;
    items_sent    = 0;
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tuser      = MODE_COUNT;
    in_tdata      = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    run_directed();
    run_random();
    @(negedge clk);
    in_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("%0d items in %0d cycles: %0d search hits (deepest position %0d), %0d misses",
             items_sent, cycle_count, sb.hits, sb.deepest, sb.misses);
    $display("%0d pushes dropped on a full list, %0d entries held at the end",
             sb.dropped, sb.held);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
